// ===== src/des_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// des_pkg
// Shared types, permutation tables, S-boxes and permutation functions for the
// DES block encryptor. Table entries use DES numbering: 1 is the MSB.
// ----------------------------------------------------------------------------
package des_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_OUT
  } state_t;

  // configuration register indexes
  localparam logic REG_DES_KEY      = 1'b0;
  localparam logic REG_REPEAT_COUNT = 1'b1;

  localparam int NUM_ROUNDS = 16;

  typedef struct packed {
    logic [3:0] idx;   // round within the pass
    logic       last;  // last round of the pass: halves swap
  } round_ctl_t;

  // 1 = rotate by two, 0 = rotate by one; index is the round number
  localparam logic [NUM_ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8,  7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7,  7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6,  7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5,  7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4,  7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3,  7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2,  7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1,  7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
    7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  function automatic logic [63:0] ip_perm(input logic [63:0] x);
    logic [63:0] y;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      y[63-i] = x[6'(7'd64 - IP_TAB[i])];
    end
    return y;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] x);
    logic [63:0] y;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      y[63-i] = x[6'(7'd64 - FP_TAB[i])];
    end
    return y;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] x);
    logic [55:0] y;
    y = '0;
    for (int i = 0; i < 56; i++) begin
      y[55-i] = x[6'(7'd64 - PC1_TAB[i])];
    end
    return y;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] x);
    logic [47:0] y;
    y = '0;
    for (int i = 0; i < 48; i++) begin
      y[47-i] = x[6'd56 - PC2_TAB[i]];
    end
    return y;
  endfunction

  function automatic logic [47:0] e_perm(input logic [31:0] x);
    logic [47:0] y;
    y = '0;
    for (int i = 0; i < 48; i++) begin
      y[47-i] = x[5'(6'd32 - E_TAB[i])];
    end
    return y;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] x);
    logic [31:0] y;
    y = '0;
    for (int i = 0; i < 32; i++) begin
      y[31-i] = x[5'(6'd32 - P_TAB[i])];
    end
    return y;
  endfunction

  // row from the outer bits, column from the inner four
  function automatic logic [31:0] sbox_sub(input logic [47:0] x);
    logic [31:0] y;
    logic [5:0]  six;
    y = '0;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      y[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
    end
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== src/des_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// des_round
// One DES round: advances the C/D key halves, derives the subkey through PC-2
// and applies the Feistel function to the block halves.
// ----------------------------------------------------------------------------
module des_round (
  input  wire logic [31:0]        l,
  input  wire logic [31:0]        r,
  input  wire logic [27:0]        c,
  input  wire logic [27:0]        d,
  input  wire des_pkg::round_ctl_t ctl,
  output logic      [31:0]        l_next,
  output logic      [31:0]        r_next,
  output logic      [27:0]        c_next,
  output logic      [27:0]        d_next
);

  logic [47:0] subkey;
  logic [31:0] f_out;
  logic [31:0] mixed;

  always_comb begin
    if (des_pkg::ROT_TWO[ctl.idx]) begin
      c_next = {c[25:0], c[27:26]};
      d_next = {d[25:0], d[27:26]};
    end else begin
      c_next = {c[26:0], c[27]};
      d_next = {d[26:0], d[27]};
    end
  end

  assign subkey = des_pkg::pc2_perm({c_next, d_next});
  assign f_out  = des_pkg::p_perm(des_pkg::sbox_sub(des_pkg::e_perm(r) ^ subkey));
  assign mixed  = l ^ f_out;

  // the pass ends with the half swap, folded into its last round
  always_comb begin
    if (ctl.last) begin
      l_next = mixed;
      r_next = r;
    end else begin
      l_next = r;
      r_next = mixed;
    end
  end

endmodule
`default_nettype wire

// ===== src/des_block_encrypt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// des_block_encrypt
// DES encryption of one 64-bit block with a configurable number of 16-round
// passes between the initial and final permutations.
// ----------------------------------------------------------------------------
// One block at a time through a single round unit, one round per clock. A
// block is taken in the cycle it is accepted, then runs repeat_count passes
// through the round unit, then holds its result until taken; the block is
// ready again the cycle after that. The key is kept as its PC-1 halves;
// they rotate a full 28 positions over each pass and so need no reload
// between passes or blocks.
module des_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        plaintext_valid,
  output logic             plaintext_stall,
  input  wire logic [63:0] plaintext_block,
  output logic             ciphertext_valid,
  input  wire logic        ciphertext_stall,
  output logic      [63:0] ciphertext_block
);

  des_pkg::state_t state, state_next;

  logic [15:0] repeat_count, repeat_count_next;
  logic [27:0] key_c, key_c_next;
  logic [27:0] key_d, key_d_next;
  logic [31:0] blk_l, blk_l_next;
  logic [31:0] blk_r, blk_r_next;
  logic [3:0]  rnd, rnd_next;
  logic [15:0] passes_left, passes_left_next;

  logic [63:0] blk_ip;
  logic [55:0] key_pc1;

  des_pkg::round_ctl_t ctl;
  logic [31:0] unit_l, unit_r;
  logic [27:0] unit_c, unit_d;

  assign blk_ip  = des_pkg::ip_perm(plaintext_block);
  assign key_pc1 = des_pkg::pc1_perm(cfg_data);

  assign ctl = '{idx: rnd, last: (rnd == 4'd15)};

  des_round u_round (
    .l      (blk_l),
    .r      (blk_r),
    .c      (key_c),
    .d      (key_d),
    .ctl    (ctl),
    .l_next (unit_l),
    .r_next (unit_r),
    .c_next (unit_c),
    .d_next (unit_d)
  );

  assign plaintext_stall  = (state != des_pkg::ST_IDLE);
  assign ciphertext_valid = (state == des_pkg::ST_OUT);
  assign ciphertext_block = des_pkg::fp_perm({blk_l, blk_r});

  always_comb begin
    state_next        = state;
    repeat_count_next = repeat_count;
    key_c_next        = key_c;
    key_d_next        = key_d;
    blk_l_next        = blk_l;
    blk_r_next        = blk_r;
    rnd_next          = rnd;
    passes_left_next  = passes_left;

    case (state)
      des_pkg::ST_IDLE: begin
        if (plaintext_valid) begin
          blk_l_next       = blk_ip[63:32];
          blk_r_next       = blk_ip[31:0];
          rnd_next         = 4'd0;
          passes_left_next = repeat_count;
          // zero passes: FP undoes IP, so the block goes straight to ST_OUT
          state_next = (repeat_count == 16'd0) ? des_pkg::ST_OUT : des_pkg::ST_ROUND;
        end
      end
      des_pkg::ST_ROUND: begin
        blk_l_next = unit_l;
        blk_r_next = unit_r;
        key_c_next = unit_c;
        key_d_next = unit_d;
        rnd_next   = rnd + 4'd1;
        if (ctl.last) begin
          passes_left_next = passes_left - 16'd1;
          if (passes_left == 16'd1) begin
            state_next = des_pkg::ST_OUT;
          end
        end
      end
      des_pkg::ST_OUT: begin
        if (!ciphertext_stall) begin
          state_next = des_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = des_pkg::ST_IDLE;
      end
    endcase

    if (cfg_write) begin
      case (cfg_index)
        des_pkg::REG_DES_KEY: begin
          key_c_next = key_pc1[55:28];
          key_d_next = key_pc1[27:0];
        end
        des_pkg::REG_REPEAT_COUNT: begin
          repeat_count_next = cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= des_pkg::ST_IDLE;
      repeat_count <= 16'd1;
      key_c        <= '0;
      key_d        <= '0;
      rnd          <= '0;
      passes_left  <= '0;
    end else begin
      state        <= state_next;
      repeat_count <= repeat_count_next;
      key_c        <= key_c_next;
      key_d        <= key_d_next;
      rnd          <= rnd_next;
      passes_left  <= passes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    blk_l <= blk_l_next;
    blk_r <= blk_r_next;
  end

`ifndef SYNTHESIS
  a_busy_while_output: assert property (@(posedge clk) disable iff (rst)
    ciphertext_valid |-> plaintext_stall)
    else $error("input ready while a result is pending");

  a_zero_pass_direct: assert property (@(posedge clk) disable iff (rst)
    (plaintext_valid && !plaintext_stall && repeat_count == 16'd0) |=> ciphertext_valid)
    else $error("zero-pass block did not go straight to output");

  a_round_advance: assert property (@(posedge clk) disable iff (rst)
    (state == des_pkg::ST_ROUND && rnd != 4'd15) |=>
      (state == des_pkg::ST_ROUND && rnd == $past(rnd) + 4'd1))
    else $error("round sequencer skipped or left early");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (ciphertext_valid && !ciphertext_stall) |=> !ciphertext_valid)
    else $error("result delivered twice");
`endif

endmodule
`default_nettype wire
